>>> src/kfp_pkg.sv
`timescale 1ns / 1ps

package kfp_pkg;

  // Largest body (data plus checksum) that the parser will pass on.
  localparam int unsigned MaxBody = 256;

  localparam int unsigned CapW     = 10;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned LenW     = 9;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CapW-1:0]     CapReset     = 10'd64;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd1000;

  // Format byte fields.
  localparam logic [7:0] FmtAddrMask = 8'hC0;
  localparam logic [7:0] FmtLenMask  = 8'h3F;
  localparam logic [7:0] FmtZero     = 8'h00;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgIdxCapacity = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxTimeout  = 1'd1;

  // Input command codes.
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Result kind codes.
  localparam logic KindBody  = 1'b0;
  localparam logic KindError = 1'b1;

  // Error codes.
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrTimeout = 2'd1;
  localparam logic [1:0] ErrTooLong = 2'd2;

  typedef enum logic [2:0] {
    PhFormat = 3'd0,
    PhTarget = 3'd1,
    PhSource = 3'd2,
    PhLength = 3'd3,
    PhBody   = 3'd4
  } kfp_phase_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } kfp_in_t;

  typedef struct packed {
    logic            kind;
    logic [7:0]      body_byte;
    logic            is_last;
    logic [LenW-1:0] frame_length;
    logic [7:0]      target_addr;
    logic [7:0]      source_addr;
    logic [1:0]      error_code;
  } kfp_out_t;

  typedef struct packed {
    logic [CapW-1:0]     buffer_capacity;
    logic [TimeoutW-1:0] timeout_ms;
  } kfp_cfg_t;

endpackage

>>> src/kfp_cfg_regs.sv
`timescale 1ns / 1ps

module kfp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kfp_pkg::CfgDataW-1:0] cfg_data_i,
  output kfp_pkg::kfp_cfg_t            cfg_o
);

  kfp_pkg::kfp_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kfp_pkg::CfgIdxCapacity:
          cfg_d.buffer_capacity = cfg_data_i[kfp_pkg::CapW-1:0];
        kfp_pkg::CfgIdxTimeout:
          cfg_d.timeout_ms = cfg_data_i[kfp_pkg::TimeoutW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.buffer_capacity <= kfp_pkg::CapReset;
      cfg_q.timeout_ms      <= kfp_pkg::TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/kfp_in_stage.sv
`timescale 1ns / 1ps

module kfp_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  kfp_pkg::kfp_in_t in_item_i,
  output logic             item_valid_o,
  output kfp_pkg::kfp_in_t item_o,
  input  logic             item_take_i
);

  logic             valid_q, valid_d;
  kfp_pkg::kfp_in_t item_q, item_d;
  logic             load;

  // Register may refill in the same cycle it hands its item on.
  assign in_stall_o = valid_q && !item_take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = in_item_i;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> src/kfp_parser.sv
`timescale 1ns / 1ps

module kfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kfp_pkg::kfp_cfg_t cfg_i,
  input  logic              item_valid_i,
  input  kfp_pkg::kfp_in_t  item_i,
  output logic              item_take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kfp_pkg::kfp_out_t out_item_o
);

  localparam logic [kfp_pkg::LenW-1:0] MaxBodyLen = kfp_pkg::LenW'(kfp_pkg::MaxBody);

  kfp_pkg::kfp_phase_e             phase_q, phase_d, phase_eff;
  logic                            needs_len_q, needs_len_d;
  logic [kfp_pkg::LenW-1:0]        exp_len_q, exp_len_d;
  logic [kfp_pkg::LenW-1:0]        seen_q, seen_d;
  logic [kfp_pkg::TimeoutW-1:0]    timer_q, timer_d;
  logic [7:0]                      tgt_q, tgt_d;
  logic [7:0]                      src_q, src_d;

  logic                            out_valid_q, out_valid_d;
  kfp_pkg::kfp_out_t               out_q, out_d;

  logic                            out_free;
  logic                            res_valid;
  kfp_pkg::kfp_out_t               res;

  // Header check inputs.
  logic                            hdr_done;
  logic [kfp_pkg::LenW-1:0]        hdr_len;
  logic                            too_long;

  logic [7:0]                      b;
  logic [5:0]                      fmt_len;
  logic                            fmt_needs_len;
  logic [kfp_pkg::LenW-1:0]        fmt_exp;
  logic [kfp_pkg::LenW-1:0]        seen_inc;
  logic                            last;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign item_take_o = item_valid_i && out_free;

  assign b             = item_i.rx_byte;
  assign fmt_len       = 6'(b & kfp_pkg::FmtLenMask);
  assign fmt_needs_len = (fmt_len == 6'd0);
  assign fmt_exp       = fmt_needs_len ? '0 : kfp_pkg::LenW'(fmt_len) + 1'b1;
  assign seen_inc      = seen_q + 1'b1;
  assign last          = (seen_inc >= exp_len_q);

  assign too_long = ({1'b0, hdr_len} >= cfg_i.buffer_capacity) || (hdr_len > MaxBodyLen);

  // Codes outside the phase list behave as waiting for a format byte.
  always_comb begin
    unique case (phase_q)
      kfp_pkg::PhFormat, kfp_pkg::PhTarget, kfp_pkg::PhSource,
      kfp_pkg::PhLength, kfp_pkg::PhBody: phase_eff = phase_q;
      default:                            phase_eff = kfp_pkg::PhFormat;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    needs_len_d = needs_len_q;
    exp_len_d   = exp_len_q;
    seen_d      = seen_q;
    timer_d     = timer_q;
    tgt_d       = tgt_q;
    src_d       = src_q;
    res_valid   = 1'b0;
    res         = '0;
    hdr_done    = 1'b0;
    hdr_len     = exp_len_q;

    if (item_i.cmd == kfp_pkg::CmdTick) begin
      if (phase_eff != kfp_pkg::PhFormat) begin
        if (timer_q >= cfg_i.timeout_ms) begin
          res_valid      = 1'b1;
          res.kind       = kfp_pkg::KindError;
          res.error_code = kfp_pkg::ErrTimeout;
          phase_d        = kfp_pkg::PhFormat;
          timer_d        = '0;
          seen_d         = '0;
        end else begin
          timer_d = timer_q + 1'b1;
        end
      end
    end else begin
      unique case (phase_eff)
        kfp_pkg::PhFormat: begin
          needs_len_d = fmt_needs_len;
          exp_len_d   = fmt_exp;
          tgt_d       = '0;
          src_d       = '0;
          seen_d      = '0;
          timer_d     = '0;
          if ((b & kfp_pkg::FmtAddrMask) != kfp_pkg::FmtZero) begin
            phase_d = kfp_pkg::PhTarget;
          end else if (fmt_needs_len) begin
            phase_d = kfp_pkg::PhLength;
          end else begin
            hdr_done = 1'b1;
            hdr_len  = fmt_exp;
          end
        end
        kfp_pkg::PhTarget: begin
          tgt_d   = b;
          phase_d = kfp_pkg::PhSource;
        end
        kfp_pkg::PhSource: begin
          src_d = b;
          if (needs_len_q) begin
            phase_d = kfp_pkg::PhLength;
            timer_d = '0;
          end else begin
            hdr_done = 1'b1;
          end
        end
        kfp_pkg::PhLength: begin
          exp_len_d = kfp_pkg::LenW'(b) + 1'b1;
          hdr_done  = 1'b1;
          hdr_len   = exp_len_d;
        end
        kfp_pkg::PhBody: begin
          res_valid       = 1'b1;
          res.kind        = kfp_pkg::KindBody;
          res.body_byte   = b;
          res.is_last     = last;
          res.frame_length = last ? exp_len_q : '0;
          res.target_addr = tgt_q;
          res.source_addr = src_q;
          res.error_code  = kfp_pkg::ErrNone;
          if (last) begin
            phase_d = kfp_pkg::PhFormat;
            timer_d = '0;
            seen_d  = '0;
          end else begin
            seen_d = seen_inc;
          end
        end
        default: phase_d = kfp_pkg::PhFormat;
      endcase

      if (hdr_done) begin
        seen_d  = '0;
        timer_d = '0;
        if (too_long) begin
          res_valid      = 1'b1;
          res.kind       = kfp_pkg::KindError;
          res.error_code = kfp_pkg::ErrTooLong;
          phase_d        = kfp_pkg::PhFormat;
        end else begin
          phase_d = kfp_pkg::PhBody;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = item_take_o && res_valid;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= kfp_pkg::PhFormat;
      needs_len_q <= 1'b0;
      exp_len_q   <= '0;
      seen_q      <= '0;
      timer_q     <= '0;
      tgt_q       <= '0;
      src_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (item_take_o) begin
        phase_q     <= phase_d;
        needs_len_q <= needs_len_d;
        exp_len_q   <= exp_len_d;
        seen_q      <= seen_d;
        timer_q     <= timer_d;
        tgt_q       <= tgt_d;
        src_q       <= src_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Body phase always has a pending byte count within range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == kfp_pkg::PhBody |-> exp_len_q != '0 && seen_q < exp_len_q
                                   && exp_len_q <= MaxBodyLen)
    else $error("body phase with bad byte count");

  // Any error result sends the parser back to waiting for a format byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && res_valid && res.kind == kfp_pkg::KindError
      |=> phase_q == kfp_pkg::PhFormat && seen_q == '0 && timer_q == '0)
    else $error("parser not reset after error");

  // Last body byte carries the frame length; errors carry a code and no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == kfp_pkg::KindBody && out_q.is_last
      |-> out_q.frame_length != '0 && out_q.error_code == kfp_pkg::ErrNone)
    else $error("last body byte without frame length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == kfp_pkg::KindError
      |-> out_q.error_code != kfp_pkg::ErrNone && !out_q.is_last
          && out_q.frame_length == '0)
    else $error("error result malformed");

endmodule

>>> src/kwp2000_frame_header_parser.sv
`timescale 1ns / 1ps

// KWP2000 (ISO 14230) receive frame parser. Each input transfer is either a
// received K-line byte (cmd 0) or a one millisecond tick (cmd 1). The parser
// decodes the format byte; if either top bit is set a target and a source
// byte follow, and if the low six bits are zero a separate length byte comes
// after the addresses. It then forwards length+1 body bytes (data plus the
// unchecked checksum), one output transfer each, flagging the last with
// is_last and frame_length. A body length at or above buffer_capacity (or
// above 256) yields one error transfer with code 2; a wait for the address
// bytes, the length byte or the body that sees more than timeout_ms ticks
// yields code 1. Ticks while idle are ignored. Both errors return the
// parser to waiting for a format byte. Rate: one input transfer per clock,
// sustained while the output is not stalled; a result held by a stalled
// output also stalls the input. A result passes through the input register
// and the single-pass decode into the result register. Configuration
// writes are always ready and take effect on the next clock; write them
// only while no transfer is in flight.

module kwp2000_frame_header_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  kfp_pkg::kfp_in_t             in_item_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output kfp_pkg::kfp_out_t            out_item_o,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kfp_pkg::CfgDataW-1:0] cfg_data_i
);

  kfp_pkg::kfp_cfg_t cfg;
  logic              item_valid;
  kfp_pkg::kfp_in_t  item;
  logic              item_take;

  // buffer_capacity and timeout_ms
  kfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register; refills in the same clock it hands over.
  kfp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Phase state, header decode, body counting and the result register.
  kfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
